// File: rtl/vn_pkg.sv
// Shared types and constants for the vector normalizer.
`timescale 1ns / 1ps
`default_nettype none
package vn_pkg;

  localparam int CompWidth  = 16;
  localparam int FracBits   = 14;
  localparam int UnitWidth  = FracBits + 2;
  localparam int AbsWidth   = CompWidth;
  localparam int SqWidth    = 2 * CompWidth;
  localparam int SumWidth   = SqWidth + 2;
  localparam int RootWidth  = SumWidth / 2;
  localparam int RemWidth   = SumWidth + 1;
  localparam int QuotWidth  = FracBits + 1;
  localparam int DivWidth   = AbsWidth + FracBits + 1;

  typedef struct packed {
    logic signed [CompWidth-1:0] x_in;
    logic signed [CompWidth-1:0] y_in;
    logic signed [CompWidth-1:0] z_in;
  } in_t;

  typedef struct packed {
    logic signed [UnitWidth-1:0] x_unit;
    logic signed [UnitWidth-1:0] y_unit;
    logic signed [UnitWidth-1:0] z_unit;
    logic                        zero_vector;
  } out_t;

  // magnitudes and signs carried alongside the root and divide stages
  typedef struct packed {
    logic [AbsWidth-1:0] ax;
    logic [AbsWidth-1:0] ay;
    logic [AbsWidth-1:0] az;
    logic                nx;
    logic                ny;
    logic                nz;
    logic                zero;
  } side_t;

endpackage
`default_nettype wire

// File: rtl/vn_square.sv
// Absolute value, squaring and sum of squares, three stages.
`timescale 1ns / 1ps
`default_nettype none
module vn_square (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           en,
  input  wire logic                           in_valid,
  input  wire vn_pkg::in_t                    in_data,
  output logic                                sum_valid,
  output logic [vn_pkg::SumWidth-1:0]         sum,
  output vn_pkg::side_t                       side
);

  logic                          va, vb;
  vn_pkg::side_t                 side_a, side_b;
  logic [vn_pkg::SqWidth-1:0]    sqx, sqy, sqz;

  function automatic logic [vn_pkg::AbsWidth-1:0] abs_of(
    input logic [vn_pkg::CompWidth-1:0] v);
    abs_of = v[vn_pkg::CompWidth-1] ? (~v + 1'b1) : v;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      sum_valid <= 1'b0;
    end else if (en) begin
      va        <= in_valid;
      vb        <= va;
      sum_valid <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_a.ax   <= abs_of(in_data.x_in);
      side_a.ay   <= abs_of(in_data.y_in);
      side_a.az   <= abs_of(in_data.z_in);
      side_a.nx   <= in_data.x_in[vn_pkg::CompWidth-1];
      side_a.ny   <= in_data.y_in[vn_pkg::CompWidth-1];
      side_a.nz   <= in_data.z_in[vn_pkg::CompWidth-1];
      side_a.zero <= (in_data.x_in == '0) && (in_data.y_in == '0) && (in_data.z_in == '0);
      sqx    <= side_a.ax * side_a.ax;
      sqy    <= side_a.ay * side_a.ay;
      sqz    <= side_a.az * side_a.az;
      side_b <= side_a;
      sum    <= vn_pkg::SumWidth'(sqx) + vn_pkg::SumWidth'(sqy)
              + vn_pkg::SumWidth'(sqz);
      side   <= side_b;
    end
  end

endmodule
`default_nettype wire

// File: rtl/vn_sqrt.sv
// Floor square root, one root bit per pipeline stage.
`timescale 1ns / 1ps
`default_nettype none
module vn_sqrt (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           en,
  input  wire logic                           in_valid,
  input  wire logic [vn_pkg::SumWidth-1:0]    sum,
  input  wire vn_pkg::side_t                  side_in,
  output logic                                root_valid,
  output logic [vn_pkg::RootWidth-1:0]        root,
  output vn_pkg::side_t                       side_out
);

  localparam int Steps = vn_pkg::RootWidth;

  logic                          vld [Steps+1];
  logic [vn_pkg::RemWidth-1:0]   rem [Steps+1];
  logic [vn_pkg::RootWidth-1:0]  rt  [Steps+1];
  vn_pkg::side_t                 sd  [Steps+1];

  assign vld[0] = in_valid;
  assign rem[0] = vn_pkg::RemWidth'(sum);
  assign rt[0]  = '0;
  assign sd[0]  = side_in;

  for (genvar s = 0; s < Steps; s++) begin : g_step
    localparam int Bit = Steps - 1 - s;
    logic [vn_pkg::RemWidth-1:0] trial;
    logic                        take;

    // (root + 2^Bit)^2 - root^2
    assign trial = (vn_pkg::RemWidth'(rt[s]) << (Bit + 1))
                 + (vn_pkg::RemWidth'(1) << (2 * Bit));
    assign take  = rem[s] >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s+1] <= take ? rem[s] - trial : rem[s];
        rt[s+1]  <= take ? (rt[s] | (vn_pkg::RootWidth'(1) << Bit)) : rt[s];
        sd[s+1]  <= sd[s];
      end
    end
  end

  assign root_valid = vld[Steps];
  assign root       = rt[Steps];
  assign side_out   = sd[Steps];

endmodule
`default_nettype wire

// File: rtl/vn_div.sv
// Three-lane restoring divide, one quotient bit per pipeline stage.
`timescale 1ns / 1ps
`default_nettype none
module vn_div (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           en,
  input  wire logic                           in_valid,
  input  wire logic [vn_pkg::RootWidth-1:0]   norm,
  input  wire vn_pkg::side_t                  side_in,
  output logic                                q_valid,
  output logic [vn_pkg::QuotWidth-1:0]        qx,
  output logic [vn_pkg::QuotWidth-1:0]        qy,
  output logic [vn_pkg::QuotWidth-1:0]        qz,
  output vn_pkg::side_t                       side_out
);

  localparam int Steps = vn_pkg::QuotWidth;
  localparam int DW    = vn_pkg::DivWidth;
  localparam int QW    = vn_pkg::QuotWidth;

  logic                          vld [Steps+1];
  logic [vn_pkg::RootWidth-1:0]  nrm [Steps+1];
  vn_pkg::side_t                 sd  [Steps+1];
  logic [DW-1:0]                 rem [Steps+1][3];
  logic [QW-1:0]                 quo [Steps+1][3];

  assign vld[0]    = in_valid;
  assign nrm[0]    = norm;
  assign sd[0]     = side_in;
  assign rem[0][0] = DW'(side_in.ax) << vn_pkg::FracBits;
  assign rem[0][1] = DW'(side_in.ay) << vn_pkg::FracBits;
  assign rem[0][2] = DW'(side_in.az) << vn_pkg::FracBits;
  assign quo[0][0] = '0;
  assign quo[0][1] = '0;
  assign quo[0][2] = '0;

  for (genvar s = 0; s < Steps; s++) begin : g_step
    localparam int Bit = Steps - 1 - s;
    logic [DW-1:0] dsh;

    assign dsh = DW'(nrm[s]) << Bit;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nrm[s+1] <= nrm[s];
        sd[s+1]  <= sd[s];
      end
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
      always_ff @(posedge clk) begin
        if (en) begin
          if (rem[s][l] >= dsh) begin
            rem[s+1][l] <= rem[s][l] - dsh;
            quo[s+1][l] <= quo[s][l] | (QW'(1) << Bit);
          end else begin
            rem[s+1][l] <= rem[s][l];
            quo[s+1][l] <= quo[s][l];
          end
        end
      end
    end
  end

  assign q_valid  = vld[Steps];
  assign qx       = quo[Steps][0];
  assign qy       = quo[Steps][1];
  assign qz       = quo[Steps][2];
  assign side_out = sd[Steps];

endmodule
`default_nettype wire

// File: rtl/vector3_normalize.sv
// Top level of the pipelined three-component vector normalizer.
//
//   channel | direction | handshake            | beat
//   in      | input     | in_valid / in_ready  | in_data  (x_in, y_in, z_in)
//   out     | output    | out_valid / out_ready| out_data (x/y/z_unit, zero_vector)
//
// One beat per cycle while the output is not stalled; 36 register stages:
// 3 square/sum stages, 17 root stages (one root bit each), 15 divide stages
// (one quotient bit each) and the output register.
// The whole pipe advances together whenever the output register is empty or
// being taken, so a stall freezes every stage in place.
// Synchronous reset clears all valid bits; data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
module vector3_normalize (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire vn_pkg::in_t   in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output vn_pkg::out_t       out_data
);

  logic                               en;
  logic                               sum_valid, root_valid, q_valid;
  logic [vn_pkg::SumWidth-1:0]        sum;
  logic [vn_pkg::RootWidth-1:0]       root;
  logic [vn_pkg::QuotWidth-1:0]       qx, qy, qz;
  vn_pkg::side_t                      side_sum, side_root, side_q;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  vn_square u_square (
    .clk, .rst, .en,
    .in_valid (in_valid && in_ready),
    .in_data,
    .sum_valid,
    .sum,
    .side     (side_sum)
  );

  vn_sqrt u_sqrt (
    .clk, .rst, .en,
    .in_valid (sum_valid),
    .sum,
    .side_in  (side_sum),
    .root_valid,
    .root,
    .side_out (side_root)
  );

  vn_div u_div (
    .clk, .rst, .en,
    .in_valid (root_valid),
    .norm     (root),
    .side_in  (side_root),
    .q_valid,
    .qx, .qy, .qz,
    .side_out (side_q)
  );

  function automatic logic [vn_pkg::UnitWidth-1:0] signed_unit(
    input logic [vn_pkg::QuotWidth-1:0] q, input logic neg, input logic zero);
    logic [vn_pkg::UnitWidth-1:0] w;
    w = vn_pkg::UnitWidth'(q);
    signed_unit = zero ? '0 : (neg ? (~w + 1'b1) : w);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.x_unit      <= signed_unit(qx, side_q.nx, side_q.zero);
      out_data.y_unit      <= signed_unit(qy, side_q.ny, side_q.zero);
      out_data.z_unit      <= signed_unit(qz, side_q.nz, side_q.zero);
      out_data.zero_vector <= side_q.zero;
    end
  end

endmodule
`default_nettype wire

// File: rtl/vn_checker.sv
// Port-level checks for the vector normalizer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module vn_checker (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         in_ready,
  input wire logic         out_valid,
  input wire logic         out_ready,
  input wire vn_pkg::out_t out_data
);

  localparam logic signed [vn_pkg::UnitWidth-1:0] One =
    vn_pkg::UnitWidth'(1) << vn_pkg::FracBits;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.zero_vector |->
      out_data.x_unit == '0 && out_data.y_unit == '0 && out_data.z_unit == '0)
    else $error("zero vector with nonzero components");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.x_unit <= One && out_data.x_unit >= -One &&
                  out_data.y_unit <= One && out_data.y_unit >= -One &&
                  out_data.z_unit <= One && out_data.z_unit >= -One)
    else $error("unit component out of range");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

endmodule

bind vector3_normalize vn_checker u_vn_checker (
  .clk, .rst, .in_ready, .out_valid, .out_ready, .out_data
);
`default_nettype wire
